@@ hdl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_QUERY      = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   value;
  } op_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   front_value;
    logic [DATA_W-1:0]   back_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } res_item_t;

  // What one row of cells does in a given cycle.
  typedef struct packed {
    logic shift_in;
    logic append;
    logic shift_out;
  } chain_cmd_t;

endpackage

@@ hdl/dq_cell.sv @@
// One storage cell of a row: loads from a neighbour or from the incoming value.
module dq_cell #(
  parameter int WIDTH = dq_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  dq_pkg::chain_cmd_t cmd,
  input  logic               hit,
  input  logic [WIDTH-1:0]   value,
  input  logic [WIDTH-1:0]   lower,
  input  logic [WIDTH-1:0]   upper,
  output logic [WIDTH-1:0]   q
);

  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      q <= lower;
    end else if (cmd.shift_out) begin
      q <= upper;
    end else if (cmd.append && hit) begin
      q <= value;
    end
  end

endmodule

@@ hdl/dq_chain.sv @@
// A row of cells packed towards cell zero; cell zero holds the end that shifts in and out.
module dq_chain #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int WIDTH = dq_pkg::VALUE_BITS_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  dq_pkg::chain_cmd_t cmd,
  input  logic [CNT_W-1:0]   cnt,
  input  logic [WIDTH-1:0]   value,
  output logic [WIDTH-1:0]   head
);

  logic [WIDTH-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower;
    logic [WIDTH-1:0] upper;
    logic             hit;

    if (i == 0) begin : g_first
      assign lower = value;
    end else begin : g_lower
      assign lower = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = q[i];
    end else begin : g_upper
      assign upper = q[i+1];
    end

    // An append lands in the first free cell, which sits at the current count.
    assign hit = (cnt == CNT_W'(i));

    dq_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .hit  (hit),
      .value(value),
      .lower(lower),
      .upper(upper),
      .q    (q[i])
    );
  end

  assign head = q[0];

endmodule

@@ hdl/double_ended_queue.sv @@
// Top level of the double-ended queue: control, count, direction and result register.
//
//   channel  signals                  beat
//   op       op_valid, op_stall, op   one operation and its value
//   res      res_valid, res_stall, res one status with front, back and count
//
// Every operation is taken in the idle state: the beat updates the rows of cells and the
// count, and the report state then loads the result register from the two row heads.
// A stalled result holds the block in its report cycle; an operation may arrive
// while the previous result still waits. Reset clears the count, direction and
// handshake state; cell contents are left as they are.
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = dq_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_stall,
  input  dq_pkg::op_item_t  op,
  output logic              res_valid,
  input  logic              res_stall,
  output dq_pkg::res_item_t res
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REPORT = 2'b10
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic                     rev;
  logic                     rev_next;
  logic [dq_pkg::STATUS_W-1:0] status;
  logic [dq_pkg::STATUS_W-1:0] status_next;

  logic                     take;
  logic                     load;
  logic                     is_push;
  logic                     is_pop;
  logic                     full;
  logic                     empty;
  logic                     low;
  logic                     do_push;
  logic                     do_pop;
  dq_pkg::chain_cmd_t       cmd_a;
  dq_pkg::chain_cmd_t       cmd_b;
  logic [VALUE_BITS-1:0]    val_w;
  logic [VALUE_BITS-1:0]    head_a;
  logic [VALUE_BITS-1:0]    head_b;
  logic [VALUE_BITS-1:0]    front_w;
  logic [VALUE_BITS-1:0]    back_w;
  logic [dq_pkg::DATA_W-1:0] front_o;
  logic [dq_pkg::DATA_W-1:0] back_o;

  assign op_stall = (state != S_IDLE);
  assign take     = op_valid && !op_stall;
  assign load     = (state == S_REPORT) && (!res_valid || !res_stall);

  assign is_push = (op.opcode == dq_pkg::OP_PUSH_BACK) || (op.opcode == dq_pkg::OP_PUSH_FRONT);
  assign is_pop  = (op.opcode == dq_pkg::OP_POP_FRONT) || (op.opcode == dq_pkg::OP_POP_BACK);
  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);

  // Row A keeps the physical low end at its cell zero, row B the high end.
  assign low = ((op.opcode == dq_pkg::OP_PUSH_FRONT) || (op.opcode == dq_pkg::OP_POP_FRONT))
               ? !rev : rev;

  assign do_push = take && is_push && !full;
  assign do_pop  = take && is_pop && !empty;

  assign cmd_a.shift_in  = do_push && low;
  assign cmd_a.append    = do_push && !low;
  assign cmd_a.shift_out = do_pop && low;
  assign cmd_b.shift_in  = do_push && !low;
  assign cmd_b.append    = do_push && low;
  assign cmd_b.shift_out = do_pop && !low;

  if (VALUE_BITS <= dq_pkg::DATA_W) begin : g_narrow
    assign val_w   = op.value[VALUE_BITS-1:0];
    assign front_o = dq_pkg::DATA_W'(front_w);
    assign back_o  = dq_pkg::DATA_W'(back_w);
  end else begin : g_wide
    assign val_w   = {{(VALUE_BITS - dq_pkg::DATA_W){1'b0}}, op.value};
    assign front_o = front_w[dq_pkg::DATA_W-1:0];
    assign back_o  = back_w[dq_pkg::DATA_W-1:0];
  end

  dq_chain #(
    .DEPTH(DEPTH),
    .WIDTH(VALUE_BITS),
    .CNT_W(CNT_W)
  ) u_chain_a (
    .clk  (clk),
    .cmd  (cmd_a),
    .cnt  (cnt),
    .value(val_w),
    .head (head_a)
  );

  dq_chain #(
    .DEPTH(DEPTH),
    .WIDTH(VALUE_BITS),
    .CNT_W(CNT_W)
  ) u_chain_b (
    .clk  (clk),
    .cmd  (cmd_b),
    .cnt  (cnt),
    .value(val_w),
    .head (head_b)
  );

  // An empty queue reports zero at both ends.
  assign front_w = empty ? '0 : (rev ? head_b : head_a);
  assign back_w  = empty ? '0 : (rev ? head_a : head_b);

  always_comb begin
    cnt_next    = cnt;
    rev_next    = rev;
    status_next = status;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          state_next  = S_REPORT;
          status_next = dq_pkg::ST_OK;
          if (is_push && full) begin
            status_next = dq_pkg::ST_PUSH_FULL;
          end else if (is_pop && empty) begin
            status_next = dq_pkg::ST_POP_EMPTY;
          end
          if (do_push) begin
            cnt_next = cnt + CNT_W'(1);
          end else if (do_pop) begin
            cnt_next = cnt - CNT_W'(1);
          end
          if (op.opcode == dq_pkg::OP_REVERSE) begin
            rev_next = !rev;
          end
        end
      end
      S_REPORT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rev       <= 1'b0;
      status    <= dq_pkg::ST_OK;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      rev    <= rev_next;
      status <= status_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.status      <= status;
      res.front_value <= front_o;
      res.back_value  <= back_o;
      res.count       <= dq_pkg::COUNT_W'(cnt);
      res.is_empty    <= empty;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("element count exceeds the depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (take && is_push && full) |=> (cnt == CNT_W'(DEPTH)))
    else $error("a push on a full queue changed the count");

  a_single_heads: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT && cnt == CNT_W'(1)) |-> (head_a == head_b))
    else $error("the two rows disagree on a single element");

endmodule

@@ sim/double_ended_queue_tb.sv @@
// Self-checking testbench for the double-ended queue: directed and random operations.
`timescale 1ns / 100ps

module double_ended_queue_tb;

  localparam int IDX_W = $clog2(dq_pkg::DEPTH_DEF);

  // Spare opcode encodings, which the block treats as a query.
  localparam logic [dq_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [dq_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              op_valid  = 1'b0;
  logic              op_stall;
  dq_pkg::op_item_t  op        = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  dq_pkg::res_item_t res;

  // Predicted deque contents and pointers.
  logic [dq_pkg::DATA_W-1:0]  dq_store [dq_pkg::DEPTH_DEF];
  logic [IDX_W-1:0]           dq_head     = '0;
  logic [dq_pkg::COUNT_W-1:0] dq_count    = '0;
  logic                       dq_reversed = 1'b0;

  dq_pkg::res_item_t pending_reports [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int mismatches   = 0;
  int ops_sent     = 0;
  int reports_seen = 0;
  int full_refused = 0;
  int empty_refused = 0;
  int times_full   = 0;

  double_ended_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  function automatic dq_pkg::res_item_t deque_step(input dq_pkg::op_item_t item);
    dq_pkg::res_item_t r;
    logic              at_low;
    logic [IDX_W-1:0]  tail;
    r = '0;
    r.status = dq_pkg::ST_OK;
    case (item.opcode)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (dq_count == dq_pkg::DEPTH_DEF) begin
          r.status = dq_pkg::ST_PUSH_FULL;
        end else begin
          // The front sits at the low end of the run unless the order is reversed.
          at_low = (item.opcode == dq_pkg::OP_PUSH_FRONT) ^ dq_reversed;
          if (at_low) begin
            dq_head = dq_head - 1'b1;
            dq_store[dq_head] = item.value;
          end else begin
            tail = dq_head + dq_count[IDX_W-1:0];
            dq_store[tail] = item.value;
          end
          dq_count = dq_count + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = dq_pkg::ST_POP_EMPTY;
        end else begin
          at_low = (item.opcode == dq_pkg::OP_POP_FRONT) ^ dq_reversed;
          if (at_low) dq_head = dq_head + 1'b1;
          dq_count = dq_count - 1'b1;
        end
      end
      dq_pkg::OP_REVERSE: dq_reversed = !dq_reversed;
      default: ;
    endcase
    if (dq_count != 0) begin
      tail = dq_head + dq_count[IDX_W-1:0] - 1'b1;
      r.front_value = dq_reversed ? dq_store[tail] : dq_store[dq_head];
      r.back_value  = dq_reversed ? dq_store[dq_head] : dq_store[tail];
    end
    r.count    = dq_count;
    r.is_empty = (dq_count == 0);
    return r;
  endfunction

  task automatic send_op(input logic [dq_pkg::OPCODE_W-1:0] code,
                         input logic [dq_pkg::DATA_W-1:0]   data);
    int                gap;
    dq_pkg::op_item_t  item;
    dq_pkg::res_item_t want;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    item.opcode = code;
    item.value  = data;
    if (gap > 0) begin
      op_valid <= 1'b0;
      op       <= {3'($urandom_range(7)), 32'($urandom())};
      repeat (gap) @(posedge clk);
    end
    op_valid <= 1'b1;
    op       <= item;
    @(posedge clk);
    while (op_stall) @(posedge clk);
    want = deque_step(item);
    pending_reports.push_back(want);
    ops_sent++;
    if (want.status == dq_pkg::ST_PUSH_FULL) full_refused++;
    if (want.status == dq_pkg::ST_POP_EMPTY) empty_refused++;
    if (want.status == dq_pkg::ST_OK && want.count == dq_pkg::DEPTH_DEF &&
        (code == dq_pkg::OP_PUSH_BACK || code == dq_pkg::OP_PUSH_FRONT)) times_full++;
  endtask

  // Lowers valid and lets the block hand back every outstanding report.
  task automatic wait_drained();
    op_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_mix(input int n_ops, input int push_pct, input int pop_pct);
    int                          r;
    logic [dq_pkg::OPCODE_W-1:0] code;
    for (int i = 0; i < n_ops; i++) begin
      r = $urandom_range(99);
      if (r < push_pct)
        code = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
      else if (r < push_pct + pop_pct)
        code = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
      else if (r < push_pct + pop_pct + 5)
        code = dq_pkg::OP_REVERSE;
      else if ($urandom_range(2) == 0)
        code = dq_pkg::OP_QUERY;
      else
        code = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
      send_op(code, pick_value());
    end
  endtask

  task automatic test_directed();
    send_op(dq_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_op(dq_pkg::OP_POP_FRONT, 32'h0);
    send_op(dq_pkg::OP_POP_BACK, 32'h0);
    send_op(dq_pkg::OP_REVERSE, 32'h0);
    send_op(dq_pkg::OP_REVERSE, 32'h0);
    send_op(dq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(dq_pkg::OP_PUSH_BACK, 32'h5A5A_A5A5);
    send_op(dq_pkg::OP_QUERY, 32'h1234_5678);
    send_op(dq_pkg::OP_REVERSE, 32'h0);
    send_op(dq_pkg::OP_PUSH_BACK, 32'hAAAA_5555);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'h5555_AAAA);
    send_op(dq_pkg::OP_POP_FRONT, 32'h0);
    send_op(dq_pkg::OP_REVERSE, 32'h0);
    send_op(dq_pkg::OP_POP_BACK, 32'h0);
    send_op(OP_SPARE_6, 32'hFFFF_FFFF);
    send_op(OP_SPARE_7, 32'h8000_0001);
    send_op(dq_pkg::OP_POP_FRONT, 32'h0);
    send_op(dq_pkg::OP_POP_BACK, 32'h0);
    send_op(dq_pkg::OP_POP_BACK, 32'h0);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_op(dq_pkg::OP_POP_BACK, 32'h0);
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    for (int i = 0; i < dq_pkg::DEPTH_DEF; i++)
      send_op($urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK, $urandom());
    send_op(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(dq_pkg::OP_REVERSE, 32'h0);
    send_op(dq_pkg::OP_PUSH_FRONT, 32'h0);
    send_op(dq_pkg::OP_QUERY, 32'h0);
    for (int i = 0; i < dq_pkg::DEPTH_DEF; i++)
      send_op($urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK, $urandom());
    send_op(dq_pkg::OP_POP_FRONT, 32'h0);
    send_op(dq_pkg::OP_REVERSE, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    // Swing between filling and emptying so both bounds are met often.
    for (int blk = 0; blk < 2; blk++) begin
      run_mix(75, 85, 5);
      run_mix(75, 5, 85);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 300;
    run_mix(60, 45, 40);
    wait_drained();
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic note_mismatch(input string             what,
                               input dq_pkg::res_item_t want,
                               input dq_pkg::res_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s (expected/actual): status %0d/%0d front %h/%h back %h/%h",
                " count %0d/%0d empty %0b/%0b"},
               $realtime, what, want.status, got.status, want.front_value, got.front_value,
               want.back_value, got.back_value, want.count, got.count,
               want.is_empty, got.is_empty);
  endtask

  always @(posedge clk) begin : report_check
    dq_pkg::res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_reports.size() == 0) begin
        note_mismatch("report with nothing outstanding", '0, res);
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (res.status !== want.status || res.front_value !== want.front_value ||
            res.back_value !== want.back_value || res.count !== want.count ||
            res.is_empty !== want.is_empty)
          note_mismatch("report mismatch", want, res);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("watchdog expired with %0d reports outstanding", pending_reports.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random_phase(0, 0);
    test_random_phase(66, 0);
    test_random_phase(0, 66);
    test_backpressure();
    test_random_phase(7, 7);
    repeat (20) @(posedge clk);
    $display("ran %0d operations and checked %0d reports; deque filled %0d times",
             ops_sent, reports_seen, times_full);
    $display("refused %0d pushes when full and %0d pops when empty, under four idling mixes",
             full_refused, empty_refused);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
